/* src/pcwrl_pkg.sv */
// Package for the per-client window rate limiter: widths, codes and the
// structs shared by the top level and the record engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcwrl_pkg;

  // Record table
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int ADDR_W    = 32;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int WIN_W     = 31;
  localparam int MAXREQ_W  = 16;
  localparam int ACTIVE_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 8'd1;

  // Reset values of the configuration registers
  localparam logic [WIN_W-1:0]    WINDOW_RESET  = 31'd60000;
  localparam logic [MAXREQ_W-1:0] MAXREQ_RESET  = 16'd60;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_PURGE = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [WIN_W-1:0]    window;
    logic [MAXREQ_W-1:0] max_req;
  } cfg_t;

  typedef struct packed {
    logic                allowed;
    logic                full;
    logic [COUNT_W-1:0]  count;
    logic [ACTIVE_W-1:0] active;
  } resp_t;

endpackage

`default_nettype wire

/* src/pcwrl_engine.sv */
// Record engine of the rate limiter: the client record memory, its scan and
// compaction sequencer and the shared age subtractor and compare unit.
// Depends on pcwrl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcwrl_engine
  import pcwrl_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  start_i,
  input  wire req_t  req_i,
  output logic       busy_o,
  output logic       res_valid_o,
  input  wire logic  res_ready_i,
  output resp_t      res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_e;

  // Record memory, one write and one registered read port
  logic [ADDR_W-1:0]  key_mem   [TABLE_DEPTH];
  logic [TIME_W-1:0]  start_mem [TABLE_DEPTH];
  logic [COUNT_W-1:0] cnt_mem   [TABLE_DEPTH];

  logic               re;
  logic [IDX_W-1:0]   ra;
  logic               we;
  logic [IDX_W-1:0]   wa;
  logic [ADDR_W-1:0]  w_key;
  logic [TIME_W-1:0]  w_start;
  logic [COUNT_W-1:0] w_cnt;

  logic [ADDR_W-1:0]  rd_key_q;
  logic [TIME_W-1:0]  rd_start_q;
  logic [COUNT_W-1:0] rd_cnt_q;

  // Sequencer state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] dst_q, dst_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             new_q, new_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  req_t             req_q, req_d;
  resp_t            res_q, res_d;

  // Shared unit: age of a record and one compare against a bound
  logic [TIME_W-1:0]  cur_start;
  logic [COUNT_W-1:0] cur_cnt;
  logic [TIME_W-1:0]  age;
  logic [TIME_W-1:0]  bound;
  logic               in_bound;
  logic [COUNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0]   used_inc;
  logic               more;
  logic               hit;
  logic               scan_end;

  // A new record starts at now with a count of zero.
  assign cur_start = new_q ? req_q.now : rd_start_q;
  assign cur_cnt   = new_q ? '0 : rd_cnt_q;
  assign age       = req_q.now - cur_start;
  // Purge keeps a record while age <= 2*window, that is age < 2*window + 1.
  assign bound     = (req_q.op == OP_PURGE) ? {cfg_i.window, 1'b1} : {1'b0, cfg_i.window};
  assign in_bound  = age < bound;
  assign cnt_inc   = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_W'(1);
  assign used_inc  = used_q + CNT_W'(1);

  assign more      = idx_q < used_q;
  assign hit       = cmp_vld_q && (rd_key_q == req_q.addr);
  // The read pipeline is empty and nothing is left to issue.
  assign scan_end  = !cmp_vld_q && !more;

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    idx_d     = idx_q;
    dst_d     = dst_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    new_d     = new_q;
    slot_d    = slot_q;
    req_d     = req_q;
    res_d     = res_q;
    re        = 1'b0;
    ra        = idx_q[IDX_W-1:0];
    we        = 1'b0;
    wa        = slot_q;
    w_key     = req_q.addr;
    w_start   = cur_start;
    w_cnt     = cnt_inc;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d     = req_i;
          idx_d     = '0;
          dst_d     = '0;
          cmp_vld_d = 1'b0;
          new_d     = 1'b0;
          state_d   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (req_q.op == OP_CHECK) begin
          if (hit) begin
            // Hold the matched record in the read register.
            slot_d  = cmp_idx_q;
            state_d = ST_UPDATE;
          end else if (scan_end) begin
            if (used_q < CNT_W'(TABLE_DEPTH)) begin
              new_d   = 1'b1;
              slot_d  = used_q[IDX_W-1:0];
              state_d = ST_UPDATE;
            end else begin
              res_d.allowed = 1'b1;
              res_d.full    = 1'b1;
              res_d.count   = '0;
              res_d.active  = ACTIVE_W'(used_q);
              state_d       = ST_RESP;
            end
          end else begin
            re        = more;
            idx_d     = more ? idx_q + CNT_W'(1) : idx_q;
            cmp_vld_d = more;
            cmp_idx_d = idx_q[IDX_W-1:0];
          end
        end else begin
          // Compaction writes never reach an address still to be read.
          if (cmp_vld_q && in_bound) begin
            we      = 1'b1;
            wa      = dst_q[IDX_W-1:0];
            w_key   = rd_key_q;
            w_start = rd_start_q;
            w_cnt   = rd_cnt_q;
            dst_d   = dst_q + CNT_W'(1);
          end
          if (scan_end) begin
            used_d        = dst_q;
            res_d.allowed = 1'b1;
            res_d.full    = 1'b0;
            res_d.count   = '0;
            res_d.active  = ACTIVE_W'(dst_q);
            state_d       = ST_RESP;
          end else begin
            re        = more;
            idx_d     = more ? idx_q + CNT_W'(1) : idx_q;
            cmp_vld_d = more;
            cmp_idx_d = idx_q[IDX_W-1:0];
          end
        end
      end

      ST_UPDATE: begin
        we            = 1'b1;
        wa            = slot_q;
        w_key         = req_q.addr;
        res_d.full    = 1'b0;
        if (in_bound) begin
          w_start       = cur_start;
          w_cnt         = cnt_inc;
          res_d.allowed = cnt_inc <= cfg_i.max_req;
        end else begin
          w_start       = req_q.now;
          w_cnt         = COUNT_W'(1);
          res_d.allowed = 1'b1;
        end
        res_d.count = w_cnt;
        used_d      = new_q ? used_inc : used_q;
        res_d.active = ACTIVE_W'(used_d);
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      idx_q     <= '0;
      dst_q     <= '0;
      cmp_vld_q <= 1'b0;
      new_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      idx_q     <= idx_d;
      dst_q     <= dst_d;
      cmp_vld_q <= cmp_vld_d;
      new_q     <= new_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    req_q     <= req_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[wa]   <= w_key;
      start_mem[wa] <= w_start;
      cnt_mem[wa]   <= w_cnt;
    end
    if (re) begin
      rd_key_q   <= key_mem[ra];
      rd_start_q <= start_mem[ra];
      rd_cnt_q   <= cnt_mem[ra];
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* src/per_client_window_rate_limiter_unit.sv */
// Per-client fixed-window rate limiter, top level: stream ports, configuration
// registers and the result register. Depends on pcwrl_pkg and pcwrl_engine.
//
// The block keeps up to 16 client records (address, window start, request
// count) and takes one item at a time: a check of one request or a purge of
// stale records. A check passes through accept, scan, update and result, a
// purge through accept, scan and result; the scan reads one record per cycle
// from the record memory, and a check that finds the table full skips the
// update. s_axis_tready is low while an item is in work, and the result waits
// in its own register, so the next item may enter while a result is still
// waiting to be taken.
// Configuration writes are always accepted and must be made only while the
// block is idle.
`timescale 1ns / 1ps
`default_nettype none

module per_client_window_rate_limiter_unit
  import pcwrl_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Input items
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [31:0] client_addr, [63:32] now_ms
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  wire logic                   s_axis_tuser,
  // Result items
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [0] allowed, [1] table_full, [17:2] client_count, [22:18] active_records,
  // [23] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  cfg_t  cfg_q;
  req_t  req;
  resp_t eng_res;
  logic  eng_busy;
  logic  eng_res_valid;
  logic  eng_res_ready;
  logic  in_fire;

  logic  m_valid_q;
  resp_t m_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window  <= WINDOW_RESET;
      cfg_q.max_req <= MAXREQ_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WINDOW_MS:    cfg_q.window  <= cfg_data_i[WIN_W-1:0];
        REG_MAX_REQUESTS: cfg_q.max_req <= cfg_data_i[MAXREQ_W-1:0];
        default:          ;
      endcase
    end
  end

  assign s_axis_tready = !eng_busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign req.op   = op_e'(s_axis_tuser);
  assign req.addr = s_axis_tdata[ADDR_W-1:0];
  assign req.now  = s_axis_tdata[ADDR_W+TIME_W-1:ADDR_W];

  pcwrl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (in_fire),
    .req_i       (req),
    .busy_o      (eng_busy),
    .res_valid_o (eng_res_valid),
    .res_ready_i (eng_res_ready),
    .res_o       (eng_res)
  );

  // The result register takes a new item when empty or being emptied.
  assign eng_res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (eng_res_valid && eng_res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_res_valid && eng_res_ready) begin
      m_data_q <= eng_res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_data_q.active, m_data_q.count, m_data_q.full,
                          m_data_q.allowed};

`ifndef SYNTHESIS
  // The engine never offers a result while it is ready for a new item.
  a_res_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_res_valid |-> !s_axis_tready)
    else $error("engine result offered while input is ready");

  // A full-table result can only come from a table that holds every record.
  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q.full) |-> (m_data_q.active == ACTIVE_W'(TABLE_DEPTH)))
    else $error("table_full reported with free records");

  // A denied request always carries a nonzero count.
  a_deny_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_data_q.allowed) |-> (m_data_q.count != '0))
    else $error("denied request with zero count");

  // An accepted item leaves the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input ready right after an accepted item");
`endif

endmodule

`default_nettype wire
